// File: src/dsa_signature_sign_macros.svh
// Assertion macros shared by the signature block.
`ifndef DSA_SIGNATURE_SIGN_MACROS_SVH
`define DSA_SIGNATURE_SIGN_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define DSS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define DSS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: src/dsa_sig_pkg.sv
// Package with shared types and constants of the signature block.
`default_nettype none
package dsa_sig_pkg;

   localparam int unsigned FIELD_W = 16;
   localparam int unsigned CSR_IDX_W = 3;

   localparam logic [FIELD_W-1:0] DIGEST_KEY = 16'd1234;

   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS_P   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SUBGROUP_Q  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GENERATOR   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PRIVATE_KEY = 3'd3;

   localparam logic [FIELD_W-1:0] RST_MODULUS_P   = 16'd67;
   localparam logic [FIELD_W-1:0] RST_SUBGROUP_Q  = 16'd11;
   localparam logic [FIELD_W-1:0] RST_GENERATOR   = 16'd1;
   localparam logic [FIELD_W-1:0] RST_PRIVATE_KEY = 16'd1;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GRED,
      ST_SQR,
      ST_MULB,
      ST_RRED,
      ST_KRED,
      ST_EDIV,
      ST_EMUL,
      ST_ECHK,
      ST_XRED,
      ST_XMUL,
      ST_DRED,
      ST_TADD,
      ST_SMUL,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

// File: src/dsa_sig_div.sv
// Bit-serial restoring divider giving quotient and remainder.
`default_nettype none
module dsa_sig_div #(
   parameter int unsigned WIDTH = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [WIDTH-1:0]     dividend,
   input  wire logic [WIDTH-1:0]     divisor,
   output dsa_sig_pkg::unit_stat_type stat,
   output logic      [WIDTH-1:0]     quotient,
   output logic      [WIDTH-1:0]     remainder
);
   import dsa_sig_pkg::*;

   localparam int unsigned CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] quot_ff, quot_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] dvs_ff, dvs_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [WIDTH:0]   trial;
   logic             ge;

   always_comb begin
      trial = {rem_ff, quot_ff[WIDTH-1]};
      ge = trial >= {1'b0, dvs_ff};
      quot_in = quot_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quot_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = CW'(WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? WIDTH'(trial - {1'b0, dvs_ff}) : trial[WIDTH-1:0];
         quot_in = {quot_ff[WIDTH-2:0], ge};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient = quot_ff;
   assign remainder = rem_ff;
endmodule
`default_nettype wire

// File: src/dsa_sig_mulmod.sv
// Bit-serial modular multiplier by doubling and conditional addition.
`default_nettype none
module dsa_sig_mulmod #(
   parameter int unsigned WIDTH = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [WIDTH-1:0]     op_a,
   input  wire logic [WIDTH-1:0]     op_b,
   input  wire logic [WIDTH-1:0]     modulus,
   output dsa_sig_pkg::unit_stat_type stat,
   output logic      [WIDTH-1:0]     product
);
   import dsa_sig_pkg::*;

   localparam int unsigned CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] a_ff, a_in;
   logic [WIDTH-1:0] b_ff, b_in;
   logic [WIDTH-1:0] m_ff, m_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [WIDTH:0]   dbl;
   logic [WIDTH-1:0] dbl_red;
   logic [WIDTH:0]   sum;

   always_comb begin
      // Operands are below the modulus, so each step needs one subtract.
      dbl = {acc_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, m_ff}) ? WIDTH'(dbl - {1'b0, m_ff}) : dbl[WIDTH-1:0];
      sum = {1'b0, dbl_red} + (b_ff[WIDTH-1] ? {1'b0, a_ff} : '0);
      a_in = a_ff;
      b_in = b_ff;
      m_in = m_ff;
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in = op_a;
         b_in = op_b;
         m_in = modulus;
         acc_in = '0;
         cnt_in = CW'(WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = (sum >= {1'b0, m_ff}) ? WIDTH'(sum - {1'b0, m_ff}) : sum[WIDTH-1:0];
         b_in = {b_ff[WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      m_ff <= m_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign product = acc_ff;
endmodule
`default_nettype wire

// File: src/dsa_signature_sign.sv
// Top level of the DSA-style signature generator with its sequencer.
`default_nettype none
`include "dsa_signature_sign_macros.svh"
// Signs one message per transfer: r = (g^k mod p) mod q and
// s = k^-1 * (digest + x*r) mod q with digest = message XOR 1234, all products exact.
// An item is handled alone, one at a time, by a sequencer that drives a bit-serial
// modular multiplier and a bit-serial divider. The exponentiation costs up to 2*WIDTH
// multiplier calls, the extended-Euclid inverse one divide and one multiply per
// quotient step (at most about 1.5*WIDTH steps), and seven more calls reduce the
// operands and form the final products. An item needs far fewer calls when the nonce
// has few set bits, and none when the subgroup order is 0 or 1.
// A finished result sits in an output register, so the next request transfer can
// start while the previous response waits. Configuration writes are always ready
// and must only be made while the block is idle; unknown register indexes are ignored.
module dsa_signature_sign #(
   parameter int unsigned WIDTH = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [dsa_sig_pkg::FIELD_W-1:0]     req_message,
   input  wire logic [dsa_sig_pkg::FIELD_W-1:0]     req_nonce,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic      [dsa_sig_pkg::FIELD_W-1:0]     rsp_sig_r,
   output logic      [dsa_sig_pkg::FIELD_W-1:0]     rsp_sig_s,
   output logic                                     rsp_no_inverse,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [dsa_sig_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [dsa_sig_pkg::FIELD_W-1:0]     csr_wdata
);
   import dsa_sig_pkg::*;

   localparam int unsigned BW = $clog2(WIDTH);

   // Configuration registers, kept at the field width.
   logic [FIELD_W-1:0] cfg_p_ff, cfg_q_ff, cfg_g_ff, cfg_x_ff;

   // Operands cut or extended to the working width.
   logic [WIDTH-1:0] p_w, q_w, g_w, x_w;

   state_type state_ff, state_in;

   logic [WIDTH-1:0] k_ff, dig_ff, acc_ff, base_ff, r_ff;
   logic [WIDTH-1:0] r0_ff, r1_ff, t0_ff, t1_ff, quo_ff, rn_ff;
   logic [WIDTH-1:0] kinv_ff, xr_ff, xrr_ff, dr_ff, s_ff;
   logic             fail_ff;
   logic [BW-1:0]    bit_ff;
   logic             wait_ff, wait_in;

   logic [FIELD_W-1:0] out_r_ff, out_s_ff;
   logic               out_f_ff, rsp_valid_ff, rsp_valid_in;

   // Unit hookup.
   logic             div_start, mul_start;
   logic [WIDTH-1:0] div_a, div_b, mul_a, mul_b, mul_m;
   unit_stat_type    div_stat, mul_stat;
   logic [WIDTH-1:0] div_quo, div_rem, mul_prod;
   logic             unit_done, op_state, out_free;

   logic [WIDTH-1:0] quo_red, t_sub, t_add;
   logic [WIDTH:0]   sub_diff, add_sum;

   assign p_w = WIDTH'(cfg_p_ff);
   assign q_w = WIDTH'(cfg_q_ff);
   assign g_w = WIDTH'(cfg_g_ff);
   assign x_w = WIDTH'(cfg_x_ff);

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_p_ff <= RST_MODULUS_P;
         cfg_q_ff <= RST_SUBGROUP_Q;
         cfg_g_ff <= RST_GENERATOR;
         cfg_x_ff <= RST_PRIVATE_KEY;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MODULUS_P:   cfg_p_ff <= csr_wdata;
            CSR_SUBGROUP_Q:  cfg_q_ff <= csr_wdata;
            CSR_GENERATOR:   cfg_g_ff <= csr_wdata;
            CSR_PRIVATE_KEY: cfg_x_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   dsa_sig_div #(.WIDTH(WIDTH)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_a),
      .divisor   (div_b),
      .stat      (div_stat),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   dsa_sig_mulmod #(.WIDTH(WIDTH)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .modulus (mul_m),
      .stat    (mul_stat),
      .product (mul_prod)
   );

   assign unit_done = div_stat.done | mul_stat.done;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // The quotient never exceeds q, so one compare reduces it.
   assign quo_red = (quo_ff >= q_w) ? WIDTH'(quo_ff - q_w) : quo_ff;
   // Update of the Bezout coefficient, taken modulo q.
   assign sub_diff = {1'b0, t0_ff} - {1'b0, mul_prod};
   assign t_sub = sub_diff[WIDTH] ? WIDTH'(sub_diff[WIDTH-1:0] + q_w) : sub_diff[WIDTH-1:0];
   assign add_sum = {1'b0, dr_ff} + {1'b0, xrr_ff};
   assign t_add = (add_sum >= {1'b0, q_w}) ? WIDTH'(add_sum - {1'b0, q_w})
                                           : add_sum[WIDTH-1:0];

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (q_w <= WIDTH'(1)) begin
                  state_in = ST_DONE;
               end else if (p_w == '0) begin
                  state_in = ST_RRED;
               end else begin
                  state_in = ST_GRED;
               end
            end
         end
         ST_GRED: if (unit_done) state_in = ST_SQR;
         ST_SQR, ST_MULB: begin
            if (unit_done) begin
               if (state_ff == ST_SQR && k_ff[bit_ff]) begin
                  state_in = ST_MULB;
               end else if (bit_ff == '0) begin
                  state_in = ST_RRED;
               end else begin
                  state_in = ST_SQR;
               end
            end
         end
         ST_RRED: if (unit_done) state_in = ST_KRED;
         ST_KRED: if (unit_done) state_in = ST_EDIV;
         ST_EDIV: begin
            if (r1_ff == '0) begin
               state_in = ST_ECHK;
            end else if (unit_done) begin
               state_in = ST_EMUL;
            end
         end
         ST_EMUL: if (unit_done) state_in = ST_EDIV;
         ST_ECHK: state_in = (r0_ff == WIDTH'(1)) ? ST_XRED : ST_DONE;
         ST_XRED: if (unit_done) state_in = ST_XMUL;
         ST_XMUL: if (unit_done) state_in = ST_DRED;
         ST_DRED: if (unit_done) state_in = ST_TADD;
         ST_TADD: state_in = ST_SMUL;
         ST_SMUL: if (unit_done) state_in = ST_DONE;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer: unit starts and operand selection.
   always_comb begin
      req_ready = 1'b0;
      op_state = 1'b0;
      div_a = '0;
      div_b = q_w;
      mul_a = '0;
      mul_b = '0;
      mul_m = q_w;
      div_start = 1'b0;
      mul_start = 1'b0;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_GRED: begin
            op_state = 1'b1;
            div_a = g_w;
            div_b = p_w;
            div_start = !wait_ff;
         end
         ST_SQR: begin
            op_state = 1'b1;
            mul_a = acc_ff;
            mul_b = acc_ff;
            mul_m = p_w;
            mul_start = !wait_ff;
         end
         ST_MULB: begin
            op_state = 1'b1;
            mul_a = acc_ff;
            mul_b = base_ff;
            mul_m = p_w;
            mul_start = !wait_ff;
         end
         ST_RRED: begin
            op_state = 1'b1;
            div_a = acc_ff;
            div_start = !wait_ff;
         end
         ST_KRED: begin
            op_state = 1'b1;
            div_a = k_ff;
            div_start = !wait_ff;
         end
         ST_EDIV: begin
            op_state = r1_ff != '0;
            div_a = r0_ff;
            div_b = r1_ff;
            div_start = !wait_ff && (r1_ff != '0);
         end
         ST_EMUL: begin
            op_state = 1'b1;
            mul_a = quo_red;
            mul_b = t1_ff;
            mul_start = !wait_ff;
         end
         ST_XRED: begin
            op_state = 1'b1;
            div_a = x_w;
            div_start = !wait_ff;
         end
         ST_XMUL: begin
            op_state = 1'b1;
            mul_a = xr_ff;
            mul_b = r_ff;
            mul_start = !wait_ff;
         end
         ST_DRED: begin
            op_state = 1'b1;
            div_a = dig_ff;
            div_start = !wait_ff;
         end
         ST_SMUL: begin
            op_state = 1'b1;
            mul_a = kinv_ff;
            mul_b = xrr_ff;
            mul_start = !wait_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      wait_in = wait_ff;
      if (div_start || mul_start) begin
         wait_in = 1'b1;
      end else if (unit_done || !op_state) begin
         wait_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == ST_DONE && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wait_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wait_ff <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               k_ff <= WIDTH'(req_nonce);
               dig_ff <= WIDTH'(req_message ^ DIGEST_KEY);
               acc_ff <= '0;
               r_ff <= '0;
               s_ff <= '0;
               fail_ff <= 1'b1;
            end
         end
         ST_GRED: begin
            if (unit_done) begin
               base_ff <= div_rem;
               acc_ff <= (p_w == WIDTH'(1)) ? '0 : WIDTH'(1);
               bit_ff <= BW'(WIDTH - 1);
            end
         end
         ST_SQR, ST_MULB: begin
            if (unit_done) begin
               acc_ff <= mul_prod;
               if (!(state_ff == ST_SQR && k_ff[bit_ff]) && bit_ff != '0) begin
                  bit_ff <= bit_ff - BW'(1);
               end
            end
         end
         ST_RRED: if (unit_done) r_ff <= div_rem;
         ST_KRED: begin
            if (unit_done) begin
               r0_ff <= q_w;
               r1_ff <= div_rem;
               t0_ff <= '0;
               t1_ff <= WIDTH'(1);
            end
         end
         ST_EDIV: begin
            if (unit_done) begin
               quo_ff <= div_quo;
               rn_ff <= div_rem;
            end
         end
         ST_EMUL: begin
            if (unit_done) begin
               r0_ff <= r1_ff;
               r1_ff <= rn_ff;
               t0_ff <= t1_ff;
               t1_ff <= t_sub;
            end
         end
         ST_ECHK: kinv_ff <= t0_ff;
         ST_XRED: if (unit_done) xr_ff <= div_rem;
         ST_XMUL: if (unit_done) xrr_ff <= mul_prod;
         ST_DRED: if (unit_done) dr_ff <= div_rem;
         ST_TADD: xrr_ff <= t_add;
         ST_SMUL: begin
            if (unit_done) begin
               s_ff <= mul_prod;
               fail_ff <= 1'b0;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_r_ff <= FIELD_W'(r_ff);
               out_s_ff <= FIELD_W'(s_ff);
               out_f_ff <= fail_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_sig_r = out_r_ff;
   assign rsp_sig_s = out_s_ff;
   assign rsp_no_inverse = out_f_ff;

   // A taken response with no new result behind it clears the response valid flag.
   `DSS_ASSERT(a_rsp_drain, (rsp_valid && rsp_ready && state_ff != ST_DONE) |=> !rsp_valid, "response not drained")
   // The divider and multiplier are never active together.
   `DSS_ASSERT(a_units_excl, !(div_stat.busy && mul_stat.busy), "both units busy")
   // Remainders shrink strictly through the inverse loop.
   `DSS_ASSERT(a_euclid_order, (state_ff == ST_EDIV) |-> (r1_ff < r0_ff), "Euclid order broken")
endmodule
`default_nettype wire
